>>> src/exs_pkg.sv
// Package for the tagged exchange sorter: defaults, sequencer steps and the control store.
package exs_pkg;

	localparam int MAX_ITEMS_DEF = 64;
	localparam int KEY_BITS_DEF = 32;
	localparam int TAG_BITS_DEF = 16;

	typedef enum logic [2:0] {
		S_LOAD,
		S_IREAD,
		S_ILATCH,
		S_CMP,
		S_IWB,
		S_EREAD,
		S_EMIT
	} step_t;

	typedef enum logic [2:0] {
		RD_NONE,
		RD_I,
		RD_J,
		RD_J_NEXT,
		RD_K,
		RD_K_NEXT
	} rd_src_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_LOAD,
		WR_SWAP,
		WR_BACK
	} wr_src_t;

	typedef enum logic [2:0] {
		C_NONE,
		C_LAST_IN,
		C_I_END,
		C_J_END,
		C_EMIT_END
	} cond_t;

	typedef struct packed {
		logic    take_in;
		rd_src_t rd_src;
		wr_src_t wr_src;
		logic    ld_cur;
		logic    set_j;
		logic    inc_j;
		logic    inc_i;
		logic    emit;
		logic    clr_idx;
		cond_t   cond;
		step_t   jump;
		step_t   next;
	} uc_t;

	function automatic uc_t ucode(step_t s);
		uc_t w;
		w = '{take_in: 1'b0, rd_src: RD_NONE, wr_src: WR_NONE, ld_cur: 1'b0,
			set_j: 1'b0, inc_j: 1'b0, inc_i: 1'b0, emit: 1'b0, clr_idx: 1'b0,
			cond: C_NONE, jump: S_LOAD, next: S_LOAD};
		unique case (s)
			S_LOAD: begin
				w.take_in = 1'b1;
				w.wr_src = WR_LOAD;
				w.clr_idx = 1'b1;
				w.cond = C_LAST_IN;
				w.jump = S_IREAD;
				w.next = S_LOAD;
			end
			S_IREAD: begin
				w.rd_src = RD_I;
				w.set_j = 1'b1;
				w.cond = C_I_END;
				w.jump = S_EREAD;
				w.next = S_ILATCH;
			end
			S_ILATCH: begin
				w.rd_src = RD_J;
				w.ld_cur = 1'b1;
				w.next = S_CMP;
			end
			S_CMP: begin
				w.rd_src = RD_J_NEXT;
				w.wr_src = WR_SWAP;
				w.inc_j = 1'b1;
				w.cond = C_J_END;
				w.jump = S_IWB;
				w.next = S_CMP;
			end
			S_IWB: begin
				w.wr_src = WR_BACK;
				w.inc_i = 1'b1;
				w.next = S_IREAD;
			end
			S_EREAD: begin
				w.rd_src = RD_K;
				w.next = S_EMIT;
			end
			S_EMIT: begin
				w.rd_src = RD_K_NEXT;
				w.emit = 1'b1;
				w.cond = C_EMIT_END;
				w.jump = S_LOAD;
				w.next = S_EMIT;
			end
			default: begin
				w.next = S_LOAD;
			end
		endcase
		return w;
	endfunction

endpackage

>>> src/exchange_sort_with_tags.sv
// Tagged exchange sorter: load, sort in place and stream out a set of keyed items.
//
// Input beats (sort_key, item_tag, is_last) are taken on in_valid & in_ready. Up to
// MAX_ITEMS beats are stored; further beats of the same set are dropped and raise
// the overflowed flag on every result of that set. The beat with is_last ends the set.
// in_ready is high only while the block is loading; it takes one load beat per cycle.
// The sort runs in a one-read, one-write memory driven by a microcoded step sequencer; the
// inner loop does one compare-and-swap per cycle, and each outer pass adds the steps
// S_IREAD, S_ILATCH and S_IWB. Once the set is sorted, results leave one per cycle
// while out_ready is high, and final_item marks the last result.
// The result sits in an output register: when the receiver stalls it holds its beat
// and the sequencer waits. After the final result is loaded into that register the
// block takes new input beats even if that result is still waiting.
// Reset clears the sequencer, fill count, overflow flag, indices and output valid; the store needs no clearing.
module exchange_sort_with_tags #(
	parameter int MAX_ITEMS = exs_pkg::MAX_ITEMS_DEF,
	parameter int KEY_BITS = exs_pkg::KEY_BITS_DEF,
	parameter int TAG_BITS = exs_pkg::TAG_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [KEY_BITS-1:0] sort_key,
	input  logic        [TAG_BITS-1:0] item_tag,
	input  logic                       is_last,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [KEY_BITS-1:0] sorted_key,
	output logic        [TAG_BITS-1:0] sorted_tag,
	output logic                       final_item,
	output logic                       overflowed
);

	localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int DW = KEY_BITS + TAG_BITS;

	exs_pkg::step_t step_q, step_d;
	exs_pkg::uc_t   uc;

	logic [DW-1:0] mem_q [MAX_ITEMS];
	logic [DW-1:0] rd_q;
	logic [DW-1:0] cur_q;
	logic [CW-1:0] count_q;
	logic          overflow_q;
	logic [IW-1:0] i_q, j_q, k_q;

	logic          out_valid_q;
	logic [DW-1:0] out_data_q;
	logic          final_q, ovf_q;

	logic          in_acc, room, slot_free, swap, emit_go, k_final, cond_hit;
	logic          rd_en, wr_en;
	logic [IW-1:0] rd_addr, wr_addr;
	logic [DW-1:0] wr_data;

	assign uc = exs_pkg::ucode(step_q);
	assign in_ready = uc.take_in;
	assign in_acc = in_valid & in_ready;
	assign room = count_q < CW'(MAX_ITEMS);
	assign slot_free = !out_valid_q || out_ready;
	assign swap = $signed(cur_q[DW-1 -: KEY_BITS]) > $signed(rd_q[DW-1 -: KEY_BITS]);
	assign emit_go = uc.emit && slot_free;
	assign k_final = (CW'(k_q) + CW'(1)) == count_q;

	always_comb begin
		unique case (uc.cond)
			exs_pkg::C_NONE:     cond_hit = 1'b0;
			exs_pkg::C_LAST_IN:  cond_hit = in_acc && is_last;
			exs_pkg::C_I_END:    cond_hit = (CW'(i_q) + CW'(1)) >= count_q;
			exs_pkg::C_J_END:    cond_hit = (CW'(j_q) + CW'(1)) == count_q;
			exs_pkg::C_EMIT_END: cond_hit = slot_free && k_final;
			default:             cond_hit = 1'b0;
		endcase
		step_d = cond_hit ? uc.jump : uc.next;
	end

	always_comb begin
		rd_en = 1'b1;
		rd_addr = i_q;
		unique case (uc.rd_src)
			exs_pkg::RD_NONE:   rd_en = 1'b0;
			exs_pkg::RD_I:      rd_addr = i_q;
			exs_pkg::RD_J:      rd_addr = j_q;
			exs_pkg::RD_J_NEXT: rd_addr = j_q + IW'(1);
			exs_pkg::RD_K:      rd_addr = k_q;
			exs_pkg::RD_K_NEXT: begin
				rd_addr = k_q + IW'(1);
				rd_en = emit_go;
			end
			default:            rd_en = 1'b0;
		endcase
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = i_q;
		wr_data = cur_q;
		unique case (uc.wr_src)
			exs_pkg::WR_NONE: wr_en = 1'b0;
			exs_pkg::WR_LOAD: begin
				wr_en = in_acc && room;
				wr_addr = count_q[IW-1:0];
				wr_data = {sort_key, item_tag};
			end
			exs_pkg::WR_SWAP: begin
				wr_en = swap;
				wr_addr = j_q;
			end
			exs_pkg::WR_BACK: begin
				wr_en = 1'b1;
				wr_addr = i_q;
			end
			default:          wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (uc.ld_cur) begin
			cur_q <= rd_q;
		end else if (uc.wr_src == exs_pkg::WR_SWAP && swap) begin
			cur_q <= rd_q;
		end
		if (emit_go) begin
			out_data_q <= rd_q;
			final_q <= k_final;
			ovf_q <= overflow_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= exs_pkg::S_LOAD;
			count_q <= '0;
			overflow_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			if (uc.take_in && in_acc) begin
				if (room) begin
					count_q <= count_q + CW'(1);
				end else begin
					overflow_q <= 1'b1;
				end
			end
			if (uc.clr_idx) begin
				i_q <= '0;
				k_q <= '0;
			end
			if (uc.set_j) begin
				j_q <= i_q + IW'(1);
			end
			if (uc.inc_j) begin
				j_q <= j_q + IW'(1);
			end
			if (uc.inc_i) begin
				i_q <= i_q + IW'(1);
			end
			if (emit_go) begin
				k_q <= k_q + IW'(1);
				if (k_final) begin
					count_q <= '0;
					overflow_q <= 1'b0;
				end
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign sorted_key = out_data_q[DW-1 -: KEY_BITS];
	assign sorted_tag = out_data_q[TAG_BITS-1:0];
	assign final_item = final_q;
	assign overflowed = ovf_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ITEMS))
		else $error("fill count exceeds capacity");

	a_drop_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !room) |=> overflow_q)
		else $error("dropped beat did not set the overflow flag");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && k_final) |=> (count_q == '0 && !overflow_q && step_q == exs_pkg::S_LOAD))
		else $error("set state not cleared after the final result");

	a_j_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == exs_pkg::S_CMP) |-> (CW'(j_q) < count_q && i_q < j_q))
		else $error("compare index out of range");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == exs_pkg::S_EMIT) |-> (CW'(k_q) < count_q))
		else $error("emit index beyond stored set");
`endif

endmodule
